// ===== hw/rtl/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg: shared types and constants of the sine voice
// Request and result formats, opcode values, fixed-point constants, the pitch
// table lookup and the elaboration-time function for the quarter-wave sine.
// ----------------------------------------------------------------------------
package svl_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned DEF_SAMPLE_RATE     = 48000;
  localparam int unsigned DEF_SINE_TABLE_BITS = 10;
  localparam int unsigned DEF_PHASE_BITS      = 32;
  localparam int unsigned DEF_OUTPUT_BITS     = 16;

  // Opcodes of the request channel.
  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_SET_PITCH = 3'd3;
  localparam logic [2:0] OP_SET_LFO  = 3'd4;

  // Field widths.
  localparam int unsigned SINE_W  = 15;  // sine magnitude, Q0.15
  localparam int unsigned LEVEL_W = 16;  // note level, Q0.16
  localparam int unsigned GAIN_W  = 17;  // release gain, Q1.16
  localparam int unsigned HZ_W    = 20;  // pitch table entry, Q16 Hz
  localparam int unsigned NUM_W   = 30;  // table entry shifted by octave
  localparam int unsigned MAG_W   = 30;  // product magnitude, Q30
  localparam int unsigned MUL_A_W = 30;  // serial multiplier, multiplicand
  localparam int unsigned MUL_B_W = 17;  // serial multiplier, multiplier

  // Fixed-point constants.
  localparam logic [31:0]        HALF_PI_Q30 = 32'd1686629713;
  localparam logic [MUL_B_W-1:0] LEVEL_SCALE = 17'd9830;   // 0.15
  localparam logic [MUL_B_W-1:0] GAIN_DECAY  = 17'd64881;  // 0.99
  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;  // 1.0
  localparam logic [GAIN_W-1:0]  GAIN_STOP   = 17'd327;    // 0.005
  localparam int unsigned        LFO_DIVISOR = 200;
  localparam int unsigned        LFO_ROUND   = 100;

  // Request and result formats.
  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  note;
    logic [15:0] velocity;
    logic        allow_release;
    logic [31:0] phase_step;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               voice_active;
  } result_t;

  // Frequency of the lowest octave for each semitone, Q16 Hz.
  function automatic logic [HZ_W-1:0] octave_hz(input logic [3:0] semi);
    logic [HZ_W-1:0] hz;
    unique case (semi)
      4'd0:    hz = 20'd535809;
      4'd1:    hz = 20'd567670;
      4'd2:    hz = 20'd601425;
      4'd3:    hz = 20'd637188;
      4'd4:    hz = 20'd675077;
      4'd5:    hz = 20'd715219;
      4'd6:    hz = 20'd757749;
      4'd7:    hz = 20'd802807;
      4'd8:    hz = 20'd850544;
      4'd9:    hz = 20'd901120;
      4'd10:   hz = 20'd954703;
      4'd11:   hz = 20'd1011473;
      default: hz = '0;
    endcase
    return hz;
  endfunction

  // Quarter-wave sine entry, sin(r/Q * pi/2) in Q0.15 with Q = 2^(tbits-2).
  // Evaluated at elaboration only, through a Taylor series in Q30.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r,
                                                     input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(r) * 64'(HALF_PI_Q30)) >> (tbits - 2);
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + t;
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + t;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 15'd32767 : v[SINE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/svl_smul.sv =====
// ----------------------------------------------------------------------------
// svl_smul: bit-serial shift-and-add multiplier
// Takes one multiplier bit per cycle, least significant first, and adds the
// shifted multiplicand into an accumulator preset with an optional rounding
// offset of one half in Q16.
// ----------------------------------------------------------------------------
module svl_smul #(
  parameter int unsigned A_W = svl_pkg::MUL_A_W,
  parameter int unsigned B_W = svl_pkg::MUL_B_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               round,
  input  logic [A_W-1:0]     mcand,
  input  logic [B_W-1:0]     mplier,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   a_sh;
  logic [B_W-1:0]   b_sh;

  // Control: busy while the multiplier bits are taken, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: conditional add of the shifted multiplicand.
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= round ? P_W'(32768) : '0;
      a_sh <= P_W'(mcand);
      b_sh <= mplier;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign product = acc;

endmodule

// ===== hw/rtl/svl_sdiv.sv =====
// ----------------------------------------------------------------------------
// svl_sdiv: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first. The quotient
// shifts into the dividend register as the dividend bits move out.
// ----------------------------------------------------------------------------
module svl_sdiv #(
  parameter int unsigned DIVD_W = 47,
  parameter int unsigned DIV_W  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVD_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] q_sh;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W+1:0]  diff;

  // Trial subtraction of the divisor from the shifted remainder.
  assign rem_sh = {rem, q_sh[DIVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  // Control: busy while the dividend bits are taken, one per cycle, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: restore the remainder when the trial borrows.
  always_ff @(posedge clk) begin
    if (start) begin
      q_sh <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (diff[DIV_W+1]) begin
        rem  <= rem_sh[DIV_W-1:0];
        q_sh <= {q_sh[DIVD_W-2:0], 1'b0};
      end else begin
        rem  <= diff[DIV_W-1:0];
        q_sh <= {q_sh[DIVD_W-2:0], 1'b1};
      end
    end
  end

  assign quotient = q_sh;

endmodule

// ===== hw/rtl/sine_voice_with_lfo_and_release_top.sv =====
// ----------------------------------------------------------------------------
// sine_voice_with_lfo_and_release_top: one sine synth voice with LFO and fade
// Pitch and LFO phase accumulators drive a quarter-wave sine ROM; the product
// of the two sines is scaled by the note level and the release gain.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds cmd_stall high while it
// works on it. Note off, set pitch and set LFO are done in the idle state
// and never raise cmd_stall. A tick on an idle voice goes straight to the
// finish state. A tick on a playing voice reads the sine ROM twice and then
// runs two or four products through one bit-serial multiplier that handles
// one multiplier bit per cycle: two while sustaining, four while releasing.
// A note on runs two passes of a bit-serial divider and one multiply. A
// finished sample waits in an output register, so the next request is taken
// while the previous sample is still stalled on the result side.
module sine_voice_with_lfo_and_release_top #(
  parameter int unsigned SAMPLE_RATE     = svl_pkg::DEF_SAMPLE_RATE,
  parameter int unsigned SINE_TABLE_BITS = svl_pkg::DEF_SINE_TABLE_BITS,
  parameter int unsigned PHASE_BITS      = svl_pkg::DEF_PHASE_BITS,
  parameter int unsigned OUTPUT_BITS     = svl_pkg::DEF_OUTPUT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  svl_pkg::cmd_t    cmd,
  output logic             result_valid,
  input  logic             result_stall,
  output svl_pkg::result_t result
);

  localparam int unsigned PB      = PHASE_BITS;
  localparam int unsigned STB     = SINE_TABLE_BITS;
  localparam int unsigned QUARTER = 2 ** (STB - 2);
  localparam int unsigned ADDR_W  = STB - 1;
  localparam int unsigned DIVD_W  = svl_pkg::NUM_W + PB - 16 + 1;
  localparam int unsigned RATE_W  = $clog2(SAMPLE_RATE + 1);
  localparam int unsigned DIV_W   = (RATE_W > 8) ? RATE_W : 8;
  localparam int unsigned HALF_RATE = SAMPLE_RATE / 2;
  localparam int unsigned MAG_W   = svl_pkg::MAG_W;
  localparam int unsigned P_W     = svl_pkg::MUL_A_W + svl_pkg::MUL_B_W;
  localparam int unsigned OUT_RND = 2 ** (30 - OUTPUT_BITS);
  localparam int unsigned OUT_LIM = 2 ** (OUTPUT_BITS - 1) - 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOTE_DIV,
    S_NOTE_LFO,
    S_NOTE_LEVEL,
    S_LOOK_A,
    S_LOOK_B,
    S_AB,
    S_WAIT_AB,
    S_WAIT_LVL,
    S_WAIT_GAIN,
    S_WAIT_DECAY,
    S_FINISH
  } state_t;

  state_t state;

  // Voice state.
  logic [PB-1:0]               pitch_phase;
  logic [PB-1:0]               lfo_phase;
  logic [PB-1:0]               pitch_step;
  logic [PB-1:0]               lfo_step;
  logic [svl_pkg::LEVEL_W-1:0] note_level;
  logic [svl_pkg::GAIN_W-1:0]  release_gain;

  // Working registers.
  logic [15:0]                 velocity;
  logic [svl_pkg::SINE_W-1:0]  sine_a;
  logic                        neg_a;
  logic                        neg_b;
  logic [MAG_W-1:0]            mag;

  // Serial unit hookup.
  logic                         mul_start;
  logic                         mul_start_next;
  logic                         mul_round;
  logic [svl_pkg::MUL_A_W-1:0]  mul_a;
  logic [svl_pkg::MUL_B_W-1:0]  mul_b;
  logic                         mul_done;
  logic [P_W-1:0]               mul_p;
  logic                         div_start;
  logic                         div_start_next;
  logic [DIVD_W-1:0]            div_n;
  logic [DIV_W-1:0]             div_d;
  logic                         div_done;
  logic [DIVD_W-1:0]            div_q;

  svl_smul #(
    .A_W(svl_pkg::MUL_A_W),
    .B_W(svl_pkg::MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .round   (mul_round),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  svl_sdiv #(
    .DIVD_W(DIVD_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Quarter-wave sine ROM, filled at elaboration.
  logic [svl_pkg::SINE_W-1:0] sine_rom [QUARTER+1];
  logic [svl_pkg::SINE_W-1:0] rom_q;
  logic [ADDR_W-1:0]          rom_addr;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign sine_rom[g] = svl_pkg::quarter_sine(g, STB);
  end

  always_ff @(posedge clk) begin
    rom_q <= sine_rom[rom_addr];
  end

  // ROM address: pitch phase in the first lookup, LFO phase after it.
  logic [PB-1:0]      look_phase;
  logic [STB-1:0]     look_idx;
  logic [ADDR_W-2:0]  look_r;
  logic               look_neg;

  assign look_phase = (state == S_LOOK_A) ? pitch_phase : lfo_phase;
  assign look_idx   = look_phase[PB-1 -: STB];
  assign look_r     = look_idx[STB-3:0];
  assign look_neg   = look_idx[STB-1];
  assign rom_addr   = look_idx[STB-2] ? (ADDR_W'(QUARTER) - {1'b0, look_r})
                                      : {1'b0, look_r};

  // Note number split into semitone and octave (n * 43 >> 9 equals n / 12).
  logic [12:0]        note_prod;
  logic [3:0]         octave;
  logic [3:0]         semi;
  logic [svl_pkg::NUM_W-1:0] note_num;
  logic [DIVD_W-1:0]  pitch_dividend;

  assign note_prod = 13'(cmd.note) * 13'd43;
  assign octave    = note_prod[12:9];
  assign semi      = 4'(cmd.note - {octave, 3'b000} - {1'b0, octave, 2'b00});
  assign note_num  = svl_pkg::NUM_W'(svl_pkg::octave_hz(semi)) << octave;
  assign pitch_dividend = (DIVD_W'(note_num) << (PB - 16)) + DIVD_W'(HALF_RATE);

  // Output scaling: round to OUTPUT_BITS, saturate, then apply the sign.
  logic [MAG_W:0] out_sum;
  logic [31:0]    out_mag;
  logic [31:0]    out_sat;
  logic [31:0]    out_val;

  assign out_sum = {1'b0, mag} + (MAG_W + 1)'(OUT_RND);
  assign out_mag = 32'(out_sum >> (31 - OUTPUT_BITS));
  assign out_sat = (out_mag > 32'(OUT_LIM)) ? 32'(OUT_LIM) : out_mag;
  assign out_val = (neg_a ^ neg_b) ? (32'd0 - out_sat) : out_sat;

  // Products as they come out of the multiplier.
  logic [MAG_W-1:0]           mul_scaled;
  logic [svl_pkg::GAIN_W-1:0] gain_next;
  logic [PB-1:0]              pitch_next;

  assign mul_scaled = mul_p[16 +: MAG_W];
  assign gain_next  = mul_p[16 +: svl_pkg::GAIN_W];
  assign pitch_next = div_q[PB-1:0];

  assign cmd_stall = (state != S_IDLE);

  // Start pulses of the serial units, registered so that they rise together with the loaded operands.
  always_comb begin
    mul_start_next = 1'b0;
    div_start_next = 1'b0;
    unique case (state)
      S_IDLE:      div_start_next = cmd_valid && (cmd.op == svl_pkg::OP_NOTE_ON);
      S_NOTE_DIV:  div_start_next = div_done;
      S_NOTE_LFO:  mul_start_next = div_done;
      S_AB:        mul_start_next = 1'b1;
      S_WAIT_AB:   mul_start_next = mul_done;
      S_WAIT_LVL:  mul_start_next = mul_done && (release_gain != '0);
      S_WAIT_GAIN: mul_start_next = mul_done;
      default: begin
      end
    endcase
  end

  // Sequencer, voice state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
      pitch_phase  <= '0;
      lfo_phase    <= '0;
      pitch_step   <= '0;
      lfo_step     <= '0;
      note_level   <= '0;
      release_gain <= svl_pkg::GAIN_ONE;
    end else begin
      mul_start <= mul_start_next;
      div_start <= div_start_next;
      // The finish state reloads the result register itself.
      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              svl_pkg::OP_NOTE_ON: begin
                velocity  <= cmd.velocity;
                div_n     <= pitch_dividend;
                div_d     <= DIV_W'(SAMPLE_RATE);
                state     <= S_NOTE_DIV;
              end
              svl_pkg::OP_NOTE_OFF: begin
                if (cmd.allow_release) begin
                  if (release_gain == '0) begin
                    release_gain <= svl_pkg::GAIN_ONE;
                  end
                end else begin
                  pitch_step <= '0;
                end
              end
              svl_pkg::OP_TICK: begin
                if (pitch_step == '0) begin
                  mag   <= '0;
                  state <= S_FINISH;
                end else begin
                  state <= S_LOOK_A;
                end
              end
              svl_pkg::OP_SET_PITCH: begin
                pitch_step <= cmd.phase_step[PB-1:0];
              end
              svl_pkg::OP_SET_LFO: begin
                lfo_step <= cmd.phase_step[PB-1:0];
              end
              default: begin
              end
            endcase
          end
        end

        // Note on: pitch step, then LFO step, then note level.
        S_NOTE_DIV: begin
          if (div_done) begin
            pitch_step <= pitch_next;
            div_n      <= DIVD_W'({1'b0, pitch_next}) + DIVD_W'(svl_pkg::LFO_ROUND);
            div_d      <= DIV_W'(svl_pkg::LFO_DIVISOR);
            state      <= S_NOTE_LFO;
          end
        end
        S_NOTE_LFO: begin
          if (div_done) begin
            lfo_step  <= pitch_next;
            mul_a     <= svl_pkg::MUL_A_W'(velocity);
            mul_b     <= svl_pkg::LEVEL_SCALE;
            mul_round <= 1'b1;
            state     <= S_NOTE_LEVEL;
          end
        end
        S_NOTE_LEVEL: begin
          if (mul_done) begin
            note_level   <= mul_p[16 +: svl_pkg::LEVEL_W];
            pitch_phase  <= '0;
            lfo_phase    <= '0;
            release_gain <= '0;
            state        <= S_IDLE;
          end
        end

        // Tick: two ROM reads, then the phases move on.
        S_LOOK_A: begin
          neg_a <= look_neg;
          state <= S_LOOK_B;
        end
        S_LOOK_B: begin
          neg_b  <= look_neg;
          sine_a <= rom_q;
          state  <= S_AB;
        end
        S_AB: begin
          mul_a       <= svl_pkg::MUL_A_W'(sine_a);
          mul_b       <= svl_pkg::MUL_B_W'(rom_q);
          mul_round   <= 1'b0;
          pitch_phase <= pitch_phase + pitch_step;
          lfo_phase   <= lfo_phase + lfo_step;
          state       <= S_WAIT_AB;
        end
        S_WAIT_AB: begin
          if (mul_done) begin
            mul_a     <= mul_p[MAG_W-1:0];
            mul_b     <= svl_pkg::MUL_B_W'(note_level);
            mul_round <= 1'b1;
            state     <= S_WAIT_LVL;
          end
        end
        S_WAIT_LVL: begin
          if (mul_done) begin
            if (release_gain != '0) begin
              mul_a     <= mul_scaled;
              mul_b     <= release_gain;
              mul_round <= 1'b1;
              state     <= S_WAIT_GAIN;
            end else begin
              mag   <= mul_scaled;
              state <= S_FINISH;
            end
          end
        end
        S_WAIT_GAIN: begin
          if (mul_done) begin
            mag       <= mul_scaled;
            mul_a     <= svl_pkg::MUL_A_W'(release_gain);
            mul_b     <= svl_pkg::GAIN_DECAY;
            mul_round <= 1'b1;
            state     <= S_WAIT_DECAY;
          end
        end
        S_WAIT_DECAY: begin
          if (mul_done) begin
            release_gain <= gain_next;
            if (gain_next <= svl_pkg::GAIN_STOP) begin
              pitch_step <= '0;
            end
            state <= S_FINISH;
          end
        end

        // Hand the sample over once the result register is free.
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result.sample       <= out_val[15:0];
            result.voice_active <= (pitch_step != '0);
            result_valid        <= 1'b1;
            state               <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/sine_voice_with_lfo_and_release_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_voice_with_lfo_and_release_top_test: self-checking bench for one voice
// A clocked driver feeds requests from a queue and a clocked monitor checks
// every sample against a bit-exact predictor of the oscillators, the level and
// the release fade. Both sides idle in random bursts. The run covers directed
// edge cases, then note phrases, step changes and random noise.
// ----------------------------------------------------------------------------
module sine_voice_with_lfo_and_release_top_test;

  // Voice constants in the default configuration.
  localparam logic [63:0] SAMPLE_HZ    = 64'd48000;
  localparam logic [63:0] HALF_PI_FX   = 64'd1686629713;
  localparam logic [63:0] LEVEL_FACTOR = 64'd9830;
  localparam logic [63:0] DECAY_FACTOR = 64'd64881;
  localparam logic [16:0] UNITY_GAIN   = 17'd65536;
  localparam logic [16:0] SILENCE_GAIN = 17'd327;
  localparam logic [63:0] SAMPLE_MAX   = 64'd32767;

  // Opcodes that the voice ignores.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  // Run shape.
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUEUE_DEPTH  = 8;
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AFTER   = 40;
  localparam int TAIL_CYCLES  = 200;
  localparam int FULL_FADE    = 560;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  svl_pkg::cmd_t    cmd = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  svl_pkg::result_t result;

  // Predicted voice state.
  logic [31:0] pitch_phase = '0;
  logic [31:0] lfo_phase = '0;
  logic [31:0] pitch_step = '0;
  logic [31:0] lfo_step = '0;
  logic [15:0] note_level = '0;
  logic [16:0] release_gain = UNITY_GAIN;

  svl_pkg::cmd_t    request_queue[$];
  svl_pkg::result_t expected_samples[$];
  svl_pkg::result_t predicted;
  bit               quiet = 1'b0;
  int               mismatch_count = 0;
  int               requests_made = 0;

  // Driver-side bookkeeping.
  int send_gap = 0;
  int send_cycle = 0;
  int send_mode = 1;

  // Monitor-side bookkeeping.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int recv_cycle = 0;
  int recv_mode = 1;
  int results_seen = 0;

  sine_voice_with_lfo_and_release_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Lowest-octave frequency of each semitone, Q16 Hz.
  function automatic logic [63:0] semitone_hz(input int unsigned k);
    logic [63:0] hz;
    case (k)
      0:       hz = 64'd535809;
      1:       hz = 64'd567670;
      2:       hz = 64'd601425;
      3:       hz = 64'd637188;
      4:       hz = 64'd675077;
      5:       hz = 64'd715219;
      6:       hz = 64'd757749;
      7:       hz = 64'd802807;
      8:       hz = 64'd850544;
      9:       hz = 64'd901120;
      10:      hz = 64'd954703;
      default: hz = 64'd1011473;
    endcase
    return hz;
  endfunction

  // Quarter-wave sine magnitude in Q0.15 through a Taylor series in Q30.
  function automatic logic [63:0] quarter_wave(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] mag;
    x    = (64'(r) * HALF_PI_FX) >> 8;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    mag  = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return (mag > SAMPLE_MAX) ? SAMPLE_MAX : mag;
  endfunction

  // Full-wave lookup from the top ten phase bits; the sign comes back apart.
  function automatic logic [63:0] sine_q15(input logic [31:0] phase, output bit neg);
    logic [9:0]  idx;
    int unsigned r;
    idx = phase[31:22];
    r   = idx[7:0];
    if (idx[8])
      r = 256 - r;
    neg = idx[9];
    return quarter_wave(r);
  endfunction

  // Applies one request to the predicted voice; returns 1 when a sample is due.
  function automatic bit advance_voice(input svl_pkg::cmd_t req,
                                       output svl_pkg::result_t res);
    logic [63:0] num;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] v;
    bit          neg_a;
    bit          neg_b;
    bit          emits;
    res   = '0;
    emits = 1'b0;
    case (req.op)
      svl_pkg::OP_NOTE_ON: begin
        num          = semitone_hz(req.note % 12) << (req.note / 12);
        pitch_phase  = '0;
        lfo_phase    = '0;
        pitch_step   = 32'(((num << 32) + (SAMPLE_HZ << 15)) / (SAMPLE_HZ << 16));
        lfo_step     = 32'((64'(pitch_step) + 64'd100) / 64'd200);
        note_level   = 16'((64'(req.velocity) * LEVEL_FACTOR + 64'd32768) >> 16);
        release_gain = '0;
      end
      svl_pkg::OP_NOTE_OFF: begin
        if (req.allow_release) begin
          if (release_gain == '0)
            release_gain = UNITY_GAIN;
        end else begin
          pitch_step = '0;
        end
      end
      svl_pkg::OP_SET_PITCH: pitch_step = req.phase_step;
      svl_pkg::OP_SET_LFO:   lfo_step = req.phase_step;
      svl_pkg::OP_TICK: begin
        emits = 1'b1;
        if (pitch_step != '0) begin
          a = sine_q15(pitch_phase, neg_a);
          b = sine_q15(lfo_phase, neg_b);
          m = a * b;
          m = (m * 64'(note_level) + 64'd32768) >> 16;
          if (release_gain != '0)
            m = (m * 64'(release_gain) + 64'd32768) >> 16;
          v = (m + (64'd1 << 14)) >> 15;
          if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
          if (neg_a != neg_b)
            v = 64'd0 - v;
          res.sample  = v[15:0];
          pitch_phase = pitch_phase + pitch_step;
          lfo_phase   = lfo_phase + lfo_step;
          // The fade decays by 0.99 per tick and silences the voice near zero.
          if (release_gain != '0) begin
            release_gain = 17'((64'(release_gain) * DECAY_FACTOR + 64'd32768) >> 16);
            if (release_gain <= SILENCE_GAIN)
              pitch_step = '0;
          end
          res.voice_active = (pitch_step != '0);
        end
      end
      default: emits = 1'b0;
    endcase
    return emits;
  endfunction

  // Decides whether an idle burst starts, by the current idling mode.
  function automatic bit idle_roll(input int mode);
    case (mode)
      0:       return 1'b0;
      1:       return $urandom_range(0, 7) == 0;
      default: return $urandom_range(0, 1) == 0;
    endcase
  endfunction

  // Driver: offers queued requests and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        if (advance_voice(cmd, predicted))
          expected_samples.push_back(predicted);
      end
      send_cycle++;
      if (send_cycle % 256 == 0)
        send_mode = $urandom_range(0, 2);
      if (cmd_valid && cmd_stall) begin
        // A stalled request stays on the bus unchanged.
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (!quiet && idle_roll(send_mode)) begin
        send_gap = $urandom_range(0, 3);
        cmd_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        cmd       <= request_queue.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks accepted samples and drives the result stall.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          if (mismatch_count < 10)
            $display("ERROR: unexpected sample %0d active %0d at %0t",
                     result.sample, result.voice_active, $realtime);
          mismatch_count++;
        end else begin
          predicted = expected_samples.pop_front();
          if (result.sample !== predicted.sample ||
              result.voice_active !== predicted.voice_active) begin
            if (mismatch_count < 10)
              $display("ERROR: sample %0d active %0d, expected %0d active %0d at %0t",
                       result.sample, result.voice_active,
                       predicted.sample, predicted.voice_active, $realtime);
            mismatch_count++;
          end
        end
      end
      recv_cycle++;
      if (recv_cycle % 256 == 0)
        recv_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // One long hold-off so that the voice backs up into its input.
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!quiet && idle_roll(recv_mode)) begin
        stall_left = $urandom_range(0, 3);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic svl_pkg::cmd_t make_request(input logic [2:0] op,
                                                 input logic [6:0] note,
                                                 input logic [15:0] velocity,
                                                 input logic allow,
                                                 input logic [31:0] step);
    svl_pkg::cmd_t c;
    c.op            = op;
    c.note          = note;
    c.velocity      = velocity;
    c.allow_release = allow;
    c.phase_step    = step;
    return c;
  endfunction

  // A request of the given op with every other field random.
  function automatic svl_pkg::cmd_t rand_request(input logic [2:0] op);
    return make_request(op, 7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)), $urandom);
  endfunction

  // Phase steps from the whole range, small steps and both extremes.
  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(1, 1 << 22);
      default: return $urandom;
    endcase
  endfunction

  // Queues one request, keeping only a few ahead of the driver.
  task automatic push_request(input svl_pkg::cmd_t c);
    while (request_queue.size() >= QUEUE_DEPTH)
      @(negedge clk);
    request_queue.push_back(c);
    if (c.op <= svl_pkg::OP_SET_LFO)
      requests_made++;
  endtask

  task automatic wait_for_drain();
    while (request_queue.size() != 0 || cmd_valid || expected_samples.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus: directed cases, then random phrases until the item budget is met.
  initial begin : stimulus
    svl_pkg::cmd_t c;
    int            ticks;
    bit            first_phrase;
    bit            paused;
    bit            fade;
    first_phrase = 1'b1;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A tick right after reset is idle; a step set after reset plays as a fade.
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_SET_LFO, '0, '0, 1'b0, '1));
    push_request(make_request(svl_pkg::OP_SET_PITCH, '0, '0, 1'b0, '1));
    push_request(make_request(svl_pkg::OP_TICK, '1, '1, 1'b1, '1));
    // Highest note at full velocity, then a release and a repeated release.
    push_request(make_request(svl_pkg::OP_NOTE_ON, 7'd127, 16'hFFFF, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_NOTE_OFF, '0, '0, 1'b1, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_NOTE_OFF, '0, '0, 1'b1, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    // Immediate stop leaves the voice idle.
    push_request(make_request(svl_pkg::OP_NOTE_OFF, '1, '1, 1'b0, '1));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    // Lowest note at zero velocity, then a stopped LFO.
    push_request(make_request(svl_pkg::OP_NOTE_ON, 7'd0, 16'h0000, 1'b1, '1));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_SET_LFO, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    // Unused opcodes are ignored.
    push_request(make_request(OP_SPARE_A, '1, '1, 1'b1, '1));
    push_request(make_request(OP_SPARE_B, '1, '1, 1'b1, '1));
    push_request(make_request(OP_SPARE_C, '1, '1, 1'b1, '1));
    // A zero pitch step makes the voice idle.
    push_request(make_request(svl_pkg::OP_SET_PITCH, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_NOTE_ON, 7'd69, 16'h8000, 1'b0, '0));
    push_request(make_request(svl_pkg::OP_TICK, '0, '0, 1'b0, '0));
    wait_for_drain();

    requests_made = 0;
    while (requests_made < RANDOM_ITEMS) begin
      if (requests_made >= RANDOM_ITEMS * 9 / 10)
        quiet = 1'b1;
      if (!paused && requests_made >= RANDOM_ITEMS / 2) begin
        // Sender holds back until every pending sample has arrived.
        paused = 1'b1;
        wait_for_drain();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // Note phrase: attack, sustain, then a stop or a fade.
          push_request(rand_request(svl_pkg::OP_NOTE_ON));
          ticks = $urandom_range(1, 24);
          repeat (ticks) begin
            if ($urandom_range(0, 7) == 0)
              push_request(make_request(svl_pkg::OP_SET_LFO, 7'($urandom_range(0, 127)),
                                        16'($urandom_range(0, 65535)),
                                        1'($urandom_range(0, 1)), rand_step()));
            push_request(rand_request(svl_pkg::OP_TICK));
          end
          c = rand_request(svl_pkg::OP_NOTE_OFF);
          if (first_phrase || $urandom_range(0, 3) != 0)
            c.allow_release = 1'b1;
          push_request(c);
          fade = first_phrase || $urandom_range(0, 11) == 0;
          first_phrase = 1'b0;
          ticks = (c.allow_release && fade) ? FULL_FADE : $urandom_range(1, 40);
          repeat (ticks) begin
            if ($urandom_range(0, 15) == 0)
              push_request(rand_request(svl_pkg::OP_NOTE_OFF));
            push_request(rand_request(svl_pkg::OP_TICK));
          end
        end
        6, 7: begin
          // Free-running steps, possibly in fade mode left from earlier.
          c = rand_request(svl_pkg::OP_SET_PITCH);
          c.phase_step = rand_step();
          push_request(c);
          c = rand_request(svl_pkg::OP_SET_LFO);
          c.phase_step = rand_step();
          push_request(c);
          ticks = $urandom_range(1, 16);
          repeat (ticks)
            push_request(rand_request(svl_pkg::OP_TICK));
        end
        default: begin
          // Noise: any opcode with random fields.
          ticks = $urandom_range(1, 6);
          repeat (ticks)
            push_request(rand_request(3'($urandom_range(0, 7))));
        end
      endcase
    end

    quiet = 1'b1;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #100000000;
    $display("tb: failure");
    $finish;
  end

endmodule
